// ===== hdl/mfcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfcm_pkg: shared constants and types of the most-frequent-character masker
// Square size, index and count widths, and the status record of the scan unit.
// ----------------------------------------------------------------------------
package mfcm_pkg;

  localparam int DIM        = 3;
  localparam int CELLS      = DIM * DIM;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W      = $clog2(CELLS + 1);
  localparam int CNT_OUT_W  = 4;
  localparam int CNT_OUT_MAX = 15;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(CELLS - 1);
  localparam logic [CHAR_W-1:0] MASK_RESET = 8'd42;

  // Status of the scan unit as seen by the top level.
  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  rd_addr;
    logic [CHAR_W-1:0] win_char;
    logic [CNT_W-1:0]  win_count;
  } scan_stat_t;

  // Clamp an occurrence count to the width of the result field.
  function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [CNT_OUT_W-1:0] r;
    if (int'(c) > CNT_OUT_MAX) begin
      r = CNT_OUT_W'(CNT_OUT_MAX);
    end else begin
      r = CNT_OUT_W'(c);
    end
    return r;
  endfunction

endpackage : mfcm_pkg
`default_nettype wire

// ===== hdl/mfcm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfcm_in_if: input channel, one character per request
// Valid/ready handshake carrying one character of the square.
// ----------------------------------------------------------------------------
interface mfcm_in_if;
  logic                         valid;
  logic                         ready;
  logic [mfcm_pkg::CHAR_W-1:0]  char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface : mfcm_in_if
`default_nettype wire

// ===== hdl/mfcm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfcm_out_if: result channel, one square position per request
// Valid/ready handshake carrying the masked character and the winner data.
// ----------------------------------------------------------------------------
interface mfcm_out_if;
  logic                           valid;
  logic                           ready;
  logic [mfcm_pkg::CHAR_W-1:0]    char_out;
  logic                           was_masked;
  logic [mfcm_pkg::CHAR_W-1:0]    winner_char;
  logic [mfcm_pkg::CNT_OUT_W-1:0] winner_count;
  logic                           last_out;

  modport source (output valid, output char_out, output was_masked, output winner_char,
                  output winner_count, output last_out, input ready);
  modport sink   (input valid, input char_out, input was_masked, input winner_char,
                  input winner_count, input last_out, output ready);
endinterface : mfcm_out_if
`default_nettype wire

// ===== hdl/mfcm_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfcm_scan: pairwise occurrence counter
// One comparator walks every (a, b) pair of the character store through a
// registered read port and keeps the first character with the highest count.
// ----------------------------------------------------------------------------
module mfcm_scan (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [mfcm_pkg::CHAR_W-1:0] rd_data,
  output mfcm_pkg::scan_stat_t             stat
);

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_LOAD = 3'b010,
    SC_CMP  = 3'b100
  } sc_state_t;

  sc_state_t                    state_r, state_nxt;
  logic [mfcm_pkg::IDX_W-1:0]   a_r, a_nxt;
  logic [mfcm_pkg::IDX_W-1:0]   b_r, b_nxt;
  logic [mfcm_pkg::CHAR_W-1:0]  cur_r, cur_nxt;
  logic [mfcm_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [mfcm_pkg::CHAR_W-1:0]  best_char_r, best_char_nxt;
  logic [mfcm_pkg::CNT_W-1:0]   best_cnt_r, best_cnt_nxt;
  logic [mfcm_pkg::CNT_W-1:0]   n_fin;
  logic [mfcm_pkg::IDX_W-1:0]   rd_addr;
  logic                         done;

  assign n_fin = n_r + mfcm_pkg::CNT_W'(rd_data == cur_r);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    best_char_nxt = best_char_r;
    best_cnt_nxt  = best_cnt_r;
    rd_addr       = '0;
    done          = 1'b0;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          a_nxt         = '0;
          best_cnt_nxt  = '0;
          best_char_nxt = '0;
          state_nxt     = SC_LOAD;
        end
      end
      SC_LOAD: begin
        // Read data now holds entry a; the first b read goes out this cycle.
        cur_nxt   = rd_data;
        b_nxt     = '0;
        n_nxt     = '0;
        state_nxt = SC_CMP;
      end
      SC_CMP: begin
        if (b_r == mfcm_pkg::LAST_IDX) begin
          // Strictly greater keeps the earliest character on a tie.
          if (n_fin > best_cnt_r) begin
            best_cnt_nxt  = n_fin;
            best_char_nxt = cur_r;
          end
          if (a_r == mfcm_pkg::LAST_IDX) begin
            done      = 1'b1;
            state_nxt = SC_IDLE;
          end else begin
            a_nxt     = a_r + 1'b1;
            rd_addr   = a_r + 1'b1;
            state_nxt = SC_LOAD;
          end
        end else begin
          b_nxt   = b_r + 1'b1;
          n_nxt   = n_fin;
          rd_addr = b_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SC_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      best_cnt_r  <= '0;
      best_char_r <= '0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      best_cnt_r  <= best_cnt_nxt;
      best_char_r <= best_char_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    n_r   <= n_nxt;
  end

  assign stat.done      = done;
  assign stat.rd_addr   = rd_addr;
  assign stat.win_char  = best_char_r;
  assign stat.win_count = best_cnt_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == SC_IDLE)
    else $error("scan started while busy");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> best_cnt_r != '0)
    else $error("scan finished with zero winner count");

  a_done_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (state_r == SC_CMP && a_r == mfcm_pkg::LAST_IDX && b_r == mfcm_pkg::LAST_IDX))
    else $error("scan done outside the final compare");

endmodule : mfcm_scan
`default_nettype wire

// ===== hdl/most_frequent_char_mask.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// most_frequent_char_mask: masks the most frequent character of a square
// Loads DIM*DIM characters, finds the mode and emits the square with the mode
// replaced by the configured mask character.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one character per request, row-major, one per cycle while
//   ready is high. Ready drops after the last character of the square.
//   The scan then compares every pair of stored characters on one shared
//   comparator. out_ch then gives CELLS requests, each passing through a
//   store read, an output load and a handshake; last_out marks the final
//   one. A stalled receiver simply holds the output register. The scan
//   compares one pair per cycle over the single read port of the store,
//   with a load step before each new character is compared.
//   cfg_wr_en writes cfg_wr_data into the mask character; write it only while
//   the block is idle.
//   Reset clears the load position and the sequencers and sets the mask to
//   '*'. No clearing pass is needed.
// ----------------------------------------------------------------------------
module most_frequent_char_mask (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mfcm_in_if.sink                          in_ch,
  mfcm_out_if.source                       out_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mfcm_pkg::CHAR_W-1:0] cfg_wr_data
);

  typedef enum logic [4:0] {
    T_LOAD      = 5'b00001,
    T_SCAN      = 5'b00010,
    T_EMIT_RD   = 5'b00100,
    T_EMIT_LD   = 5'b01000,
    T_EMIT_WAIT = 5'b10000
  } top_state_t;

  top_state_t                     st_r, st_nxt;
  logic [mfcm_pkg::IDX_W-1:0]     load_idx_r, load_idx_nxt;
  logic [mfcm_pkg::IDX_W-1:0]     emit_idx_r, emit_idx_nxt;
  logic                           start_r, start_nxt;
  logic [mfcm_pkg::CHAR_W-1:0]    mask_char_r;
  logic [mfcm_pkg::CHAR_W-1:0]    char_store_r [mfcm_pkg::CELLS];
  logic [mfcm_pkg::CHAR_W-1:0]    rd_data_r;
  logic [mfcm_pkg::IDX_W-1:0]     rd_addr;
  logic                           in_take;
  logic                           out_valid_r, out_valid_nxt;
  logic [mfcm_pkg::CHAR_W-1:0]    char_out_r;
  logic                           masked_r;
  logic [mfcm_pkg::CHAR_W-1:0]    win_char_r;
  logic [mfcm_pkg::CNT_OUT_W-1:0] win_cnt_r;
  logic                           last_r;
  logic                           out_load;
  logic                           hit;
  mfcm_pkg::scan_stat_t           scan_stat;

  mfcm_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .rd_data (rd_data_r),
    .stat    (scan_stat)
  );

  assign in_ch.ready = (st_r == T_LOAD);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign rd_addr     = (st_r == T_SCAN) ? scan_stat.rd_addr : emit_idx_r;
  assign hit         = (rd_data_r == scan_stat.win_char);

  always_comb begin
    st_nxt        = st_r;
    load_idx_nxt  = load_idx_r;
    emit_idx_nxt  = emit_idx_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    case (st_r)
      T_LOAD: begin
        if (in_take) begin
          if (load_idx_r == mfcm_pkg::LAST_IDX) begin
            load_idx_nxt = '0;
            start_nxt    = 1'b1;
            st_nxt       = T_SCAN;
          end else begin
            load_idx_nxt = load_idx_r + 1'b1;
          end
        end
      end
      T_SCAN: begin
        if (scan_stat.done) begin
          emit_idx_nxt = '0;
          st_nxt       = T_EMIT_RD;
        end
      end
      T_EMIT_RD: begin
        st_nxt = T_EMIT_LD;
      end
      T_EMIT_LD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        st_nxt        = T_EMIT_WAIT;
      end
      T_EMIT_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (emit_idx_r == mfcm_pkg::LAST_IDX) begin
            st_nxt = T_LOAD;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
            st_nxt       = T_EMIT_RD;
          end
        end
      end
      default: begin
        st_nxt        = T_LOAD;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_LOAD;
      load_idx_r  <= '0;
      emit_idx_r  <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      mask_char_r <= mfcm_pkg::MASK_RESET;
    end else begin
      st_r        <= st_nxt;
      load_idx_r  <= load_idx_nxt;
      emit_idx_r  <= emit_idx_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mask_char_r <= cfg_wr_data;
      end
    end
  end

  // Character store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (in_take) begin
      char_store_r[load_idx_r] <= in_ch.char_in;
    end
    rd_data_r <= char_store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_out_r <= hit ? mask_char_r : rd_data_r;
      masked_r   <= hit;
      win_char_r <= scan_stat.win_char;
      win_cnt_r  <= mfcm_pkg::sat_count(scan_stat.win_count);
      last_r     <= (emit_idx_r == mfcm_pkg::LAST_IDX);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_out     = char_out_r;
  assign out_ch.was_masked   = masked_r;
  assign out_ch.winner_char  = win_char_r;
  assign out_ch.winner_count = win_cnt_r;
  assign out_ch.last_out     = last_r;

  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> st_r == T_EMIT_WAIT)
    else $error("result valid outside the handshake state");

  a_full_square_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && load_idx_r == mfcm_pkg::LAST_IDX) |=> (!in_ch.ready && start_r))
    else $error("last character did not start the scan");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_out) |=> in_ch.ready)
    else $error("input not reopened after the final result");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_valid_r))
    else $error("loading while a result is pending");

endmodule : most_frequent_char_mask
`default_nettype wire
